>>> rtl/srg_pkg.sv
// Shared types, constants and the clamp_dim helper function of the seeded region growing block.
package srg_pkg;

    localparam int MAX_ROWS_DEF = 256;
    localparam int MAX_COLS_DEF = 256;
    localparam int PIX_W        = 8;
    localparam int CFG_W        = 9;
    localparam int DIM_W        = 9;
    localparam int CIDX_W       = 2;
    localparam int WORD_W       = PIX_W + 1;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef enum logic [CIDX_W-1:0] {
        CFG_SEED_LEVEL = 2'd0,
        CFG_GROW_LIMIT = 2'd1,
        CFG_IMAGE_ROWS = 2'd2,
        CFG_IMAGE_COLS = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] seed_level;
        logic [CFG_W-1:0] grow_limit;
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic in_region;
        logic last_pixel;
    } t_rsp;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] value,
                                                   input int max_dim);
        logic [DIM_W-1:0] result;
        if (value < CFG_W'(3)) begin
            result = DIM_W'(3);
        end else if (int'(value) > max_dim) begin
            result = DIM_W'(max_dim);
        end else begin
            result = DIM_W'(value);
        end
        return result;
    endfunction

endpackage

>>> rtl/srg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module srg_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/srg_cfg.sv
// Configuration registers with clamped frame size and registered pixel count.
module srg_cfg #(
    parameter int MAX_ROWS = srg_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = srg_pkg::MAX_COLS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [srg_pkg::CIDX_W-1:0]             i_cfg_idx,
    input  logic [srg_pkg::CFG_W-1:0]              i_cfg_data,
    output srg_pkg::t_cfg                          o_cfg,
    output logic [$clog2(MAX_ROWS*MAX_COLS):0]     o_total
);

    localparam int TW = $clog2(MAX_ROWS * MAX_COLS) + 1;
    localparam int DW = srg_pkg::DIM_W;
    localparam logic [DW-1:0] RST_ROWS = srg_pkg::clamp_dim(9'd256, MAX_ROWS);
    localparam logic [DW-1:0] RST_COLS = srg_pkg::clamp_dim(9'd256, MAX_COLS);
    localparam int RST_PROD = int'(RST_ROWS) * int'(RST_COLS);

    srg_pkg::t_cfg   r_cfg;
    logic [TW-1:0]   r_total;
    logic [DW-1:0]   w_rows_new;
    logic [DW-1:0]   w_cols_new;
    logic [2*DW-1:0] w_prod_rows;
    logic [2*DW-1:0] w_prod_cols;

    assign w_rows_new  = srg_pkg::clamp_dim(i_cfg_data, MAX_ROWS);
    assign w_cols_new  = srg_pkg::clamp_dim(i_cfg_data, MAX_COLS);
    assign w_prod_rows = {{DW{1'b0}}, w_rows_new} * {{DW{1'b0}}, r_cfg.cols};
    assign w_prod_cols = {{DW{1'b0}}, r_cfg.rows} * {{DW{1'b0}}, w_cols_new};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seed_level <= '0;
            r_cfg.grow_limit <= '0;
            r_cfg.rows       <= RST_ROWS;
            r_cfg.cols       <= RST_COLS;
            r_total          <= TW'(RST_PROD);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                srg_pkg::CFG_SEED_LEVEL: begin
                    r_cfg.seed_level <= i_cfg_data[srg_pkg::PIX_W-1:0];
                end
                srg_pkg::CFG_GROW_LIMIT: begin
                    r_cfg.grow_limit <= i_cfg_data;
                end
                srg_pkg::CFG_IMAGE_ROWS: begin
                    r_cfg.rows <= w_rows_new;
                    r_total    <= TW'(w_prod_rows);
                end
                srg_pkg::CFG_IMAGE_COLS: begin
                    r_cfg.cols <= w_cols_new;
                    r_total    <= TW'(w_prod_cols);
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg   = r_cfg;
    assign o_total = r_total;

endmodule

>>> rtl/srg_ctrl.sv
// Request sequencer with seed pass, growth sweeps and the shared difference compare unit.
module srg_ctrl #(
    parameter int MAX_ROWS = srg_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = srg_pkg::MAX_COLS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  srg_pkg::t_cfg                       i_cfg,
    input  logic [$clog2(MAX_ROWS*MAX_COLS):0]  i_total,
    input  logic                                i_valid,
    input  logic                                i_req_type,
    input  logic [srg_pkg::PIX_W-1:0]           i_pixel,
    input  logic                                i_out_free,
    output logic                                o_ready,
    output srg_pkg::t_rsp                       o_rsp
);

    localparam int AW = $clog2(MAX_ROWS * MAX_COLS);
    localparam int TW = AW + 1;
    localparam int DW = srg_pkg::DIM_W;
    localparam int PW = srg_pkg::PIX_W;
    localparam int WW = srg_pkg::WORD_W;

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_RDATA   = 7'b0000010,
        ST_SEED_RD = 7'b0000100,
        ST_SEED_WR = 7'b0001000,
        ST_G_CTR   = 7'b0010000,
        ST_G_CHK   = 7'b0100000,
        ST_G_NBR   = 7'b1000000
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_load_pos, n_load_pos;
    logic [AW-1:0]   r_read_pos, n_read_pos;
    logic [AW-1:0]   r_q, n_q;
    logic [DW-1:0]   r_row, n_row;
    logic [DW-1:0]   r_col, n_col;
    logic [2:0]      r_dir, n_dir;
    logic [PW-1:0]   r_fq, n_fq;
    logic            r_changed, n_changed;
    logic            r_last, n_last;

    logic            w_pix_we;
    logic            w_mask_we;
    logic [AW-1:0]   w_waddr;
    logic [WW-1:0]   w_wdata;
    logic [AW-1:0]   w_raddr;
    logic [PW-1:0]   w_pix_rdata;
    logic            w_mask_rdata;
    logic [WW-1:0]   w_rdata;

    logic [AW-1:0]   w_cols_a;
    logic [AW-1:0]   w_load_eff;
    logic [AW-1:0]   w_read_eff;
    logic            w_load_last;
    logic            w_read_last;
    logic            w_accept;
    logic [2:0]      w_dir_sel;
    logic [AW-1:0]   w_nbr_addr;
    logic [PW-1:0]   w_diff;
    logic            w_hit;
    logic            w_col_wrap;
    logic            w_pass_end;
    logic            w_adv;

    srg_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_ROWS * MAX_COLS)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (w_pix_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata[PW-1:0]),
        .i_raddr (w_raddr),
        .o_rdata (w_pix_rdata)
    );

    srg_ram #(
        .WIDTH (1),
        .DEPTH (MAX_ROWS * MAX_COLS)
    ) u_mask (
        .i_clk   (i_clk),
        .i_we    (w_mask_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata[PW]),
        .i_raddr (w_raddr),
        .o_rdata (w_mask_rdata)
    );

    assign w_rdata     = {w_mask_rdata, w_pix_rdata};
    assign w_cols_a    = AW'(i_cfg.cols);
    assign w_load_eff  = (TW'(r_load_pos) >= i_total) ? '0 : r_load_pos;
    assign w_read_eff  = (TW'(r_read_pos) >= i_total) ? '0 : r_read_pos;
    assign w_load_last = (TW'(w_load_eff) == i_total - TW'(1));
    assign w_read_last = (TW'(w_read_eff) == i_total - TW'(1));
    assign o_ready     = (r_state == ST_IDLE) && i_out_free;
    assign w_accept    = i_valid && o_ready;

    always_comb begin
        case (w_dir_sel)
            3'd0:    w_nbr_addr = r_q - w_cols_a - AW'(1);
            3'd1:    w_nbr_addr = r_q - w_cols_a;
            3'd2:    w_nbr_addr = r_q - w_cols_a + AW'(1);
            3'd3:    w_nbr_addr = r_q - AW'(1);
            3'd4:    w_nbr_addr = r_q + AW'(1);
            3'd5:    w_nbr_addr = r_q + w_cols_a - AW'(1);
            3'd6:    w_nbr_addr = r_q + w_cols_a;
            default: w_nbr_addr = r_q + w_cols_a + AW'(1);
        endcase
    end

    // The neighbor word arrives on the read port while the center value is held.
    assign w_diff = (w_rdata[PW-1:0] > r_fq) ? (w_rdata[PW-1:0] - r_fq)
                                             : (r_fq - w_rdata[PW-1:0]);
    assign w_hit  = w_rdata[PW] && ({1'b0, w_diff} < i_cfg.grow_limit);

    assign w_col_wrap = (r_col == i_cfg.cols - DW'(2));
    assign w_pass_end = w_col_wrap && (r_row == i_cfg.rows - DW'(2));
    assign w_dir_sel  = (r_state == ST_G_NBR) ? (r_dir + 3'd1) : 3'd0;

    always_comb begin
        n_state    = r_state;
        n_load_pos = r_load_pos;
        n_read_pos = r_read_pos;
        n_q        = r_q;
        n_row      = r_row;
        n_col      = r_col;
        n_dir      = r_dir;
        n_fq       = r_fq;
        n_changed  = r_changed;
        n_last     = r_last;
        w_pix_we   = 1'b0;
        w_mask_we  = 1'b0;
        w_waddr    = r_q;
        w_wdata    = '0;
        w_raddr    = r_q;
        w_adv      = 1'b0;
        o_rsp      = '0;

        case (r_state)
            ST_IDLE: begin
                w_raddr = w_read_eff;
                if (w_accept) begin
                    if (i_req_type == srg_pkg::REQ_LOAD) begin
                        w_pix_we = 1'b1;
                        w_waddr  = w_load_eff;
                        w_wdata  = {1'b0, i_pixel};
                        if (w_load_last) begin
                            n_load_pos = '0;
                            n_read_pos = '0;
                            n_q        = '0;
                            n_state    = ST_SEED_RD;
                        end else begin
                            n_load_pos = w_load_eff + AW'(1);
                        end
                    end else begin
                        n_last     = w_read_last;
                        n_read_pos = w_read_last ? '0 : (w_read_eff + AW'(1));
                        n_state    = ST_RDATA;
                    end
                end
            end
            ST_RDATA: begin
                o_rsp.valid      = 1'b1;
                o_rsp.in_region  = w_rdata[PW];
                o_rsp.last_pixel = r_last;
                n_state          = ST_IDLE;
            end
            ST_SEED_RD: begin
                n_state = ST_SEED_WR;
            end
            ST_SEED_WR: begin
                w_mask_we = 1'b1;
                w_wdata   = {(w_rdata[PW-1:0] <= i_cfg.seed_level), w_rdata[PW-1:0]};
                if (TW'(r_q) == i_total - TW'(1)) begin
                    n_row     = DW'(1);
                    n_col     = DW'(1);
                    n_q       = w_cols_a + AW'(1);
                    n_changed = 1'b0;
                    n_state   = ST_G_CTR;
                end else begin
                    n_q     = r_q + AW'(1);
                    n_state = ST_SEED_RD;
                end
            end
            ST_G_CTR: begin
                n_state = ST_G_CHK;
            end
            ST_G_CHK: begin
                n_fq = w_rdata[PW-1:0];
                if (w_rdata[PW]) begin
                    w_adv = 1'b1;
                end else begin
                    w_raddr = w_nbr_addr;
                    n_dir   = 3'd0;
                    n_state = ST_G_NBR;
                end
            end
            ST_G_NBR: begin
                w_raddr = w_nbr_addr;
                if (w_hit) begin
                    w_mask_we = 1'b1;
                    w_wdata   = {1'b1, r_fq};
                    n_changed = 1'b1;
                    w_adv     = 1'b1;
                end else if (r_dir == 3'd7) begin
                    w_adv = 1'b1;
                end else begin
                    n_dir = r_dir + 3'd1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (w_adv) begin
            if (w_pass_end) begin
                if (n_changed) begin
                    n_row     = DW'(1);
                    n_col     = DW'(1);
                    n_q       = w_cols_a + AW'(1);
                    n_changed = 1'b0;
                    n_state   = ST_G_CTR;
                end else begin
                    n_state = ST_IDLE;
                end
            end else begin
                if (w_col_wrap) begin
                    n_col = DW'(1);
                    n_row = r_row + DW'(1);
                    n_q   = r_q + AW'(3);
                end else begin
                    n_col = r_col + DW'(1);
                    n_q   = r_q + AW'(1);
                end
                n_state = ST_G_CTR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_load_pos <= '0;
            r_read_pos <= '0;
            r_changed  <= 1'b0;
            r_last     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_load_pos <= n_load_pos;
            r_read_pos <= n_read_pos;
            r_changed  <= n_changed;
            r_last     <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_row <= n_row;
        r_col <= n_col;
        r_dir <= n_dir;
        r_fq  <= n_fq;
    end

endmodule

>>> rtl/seeded_region_growing.sv
// Top level of the seeded region growing block with its output register.
// A load writes its pixel in the cycle it is accepted; a mask read is answered in ST_RDATA and
// its result is registered at the output. After a frame's last pixel, a seed pass marks each
// pixel at or below the seed level, then growth sweeps compare each unmarked interior pixel's
// neighbors in turn with one comparer until a sweep makes no change; one read port per store.
// Synchronous active-low reset clears control state; frame and mask contents are not cleared.
module seeded_region_growing #(
    parameter int MAX_ROWS = srg_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = srg_pkg::MAX_COLS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [srg_pkg::CIDX_W-1:0]    i_cfg_idx,
    input  logic [srg_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_req_type,
    input  logic [srg_pkg::PIX_W-1:0]     i_pixel,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_in_region,
    output logic                          o_last_pixel
);

    localparam int TW = $clog2(MAX_ROWS * MAX_COLS) + 1;

    srg_pkg::t_cfg  w_cfg;
    logic [TW-1:0]  w_total;
    srg_pkg::t_rsp  w_rsp;
    logic           w_out_free;
    logic           r_out_valid;
    logic           r_in_region;
    logic           r_last_pixel;

    srg_cfg #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg),
        .o_total    (w_total)
    );

    srg_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_total    (w_total),
        .i_valid    (i_valid),
        .i_req_type (i_req_type),
        .i_pixel    (i_pixel),
        .i_out_free (w_out_free),
        .o_ready    (o_ready),
        .o_rsp      (w_rsp)
    );

    assign w_out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_rsp.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rsp.valid) begin
            r_in_region  <= w_rsp.in_region;
            r_last_pixel <= w_rsp.last_pixel;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_in_region  = r_in_region;
    assign o_last_pixel = r_last_pixel;

    a_rsp_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.valid |-> !(r_out_valid && !i_ready))
        else $error("Mask read result would overwrite a stalled result.");

    a_read_gives_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_req_type == srg_pkg::REQ_READ) |=> w_rsp.valid)
        else $error("Accepted mask read produced no result.");

    a_load_no_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_req_type == srg_pkg::REQ_LOAD) |=> !w_rsp.valid)
        else $error("Pixel load produced a result.");

endmodule
